### rtl/nfr_pkg.sv
// ----------------------------------------------------------------------------
// nfr_pkg
// Shared types, sizes and codes of the network frame reassembler.
// ----------------------------------------------------------------------------
package nfr_pkg;

	// Sizing of the receive buffer and of the set of source cores.
	localparam int BUFFER_BYTES = 1024;
	localparam int CORE_COUNT   = 16;

	// Byte counter holds 0 .. BUFFER_BYTES.
	localparam int CNT_W  = $clog2(BUFFER_BYTES + 1);
	// A header that governs a frame is a legal length, 1 .. BUFFER_BYTES - 4.
	localparam int HDR_W  = $clog2(BUFFER_BYTES - 3);
	localparam int CIDX_W = (CORE_COUNT > 1) ? $clog2(CORE_COUNT) : 1;
	localparam int MAX_HDR = BUFFER_BYTES - 4;

	// Field widths of the channels.
	localparam int SRC_W   = 4;
	localparam int WORD_W  = 32;
	localparam int OFFS_W  = 8;
	localparam int FBYTE_W = 10;
	localparam int STAT_W  = 3;
	localparam int MASK_W  = 16;
	localparam int CIDX_CFG_W = 2;
	localparam int CDATA_W = 16;

	// Handshake words, bytes C0 18 11 C0 and C0 FF 31 C0.
	localparam logic [WORD_W-1:0] LINK_REQUEST  = 32'hC018_11C0;
	localparam logic [WORD_W-1:0] LINK_RESPONSE = 32'hC0FF_31C0;

	// Result status codes.
	localparam logic [STAT_W-1:0] ST_IGNORED   = 3'd0;
	localparam logic [STAT_W-1:0] ST_REPLY     = 3'd1;
	localparam logic [STAT_W-1:0] ST_CONNECTED = 3'd2;
	localparam logic [STAT_W-1:0] ST_NO_CHAN   = 3'd3;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 3'd4;
	localparam logic [STAT_W-1:0] ST_BAD_SIZE  = 3'd5;
	localparam logic [STAT_W-1:0] ST_PARTIAL   = 3'd6;
	localparam logic [STAT_W-1:0] ST_COMPLETE  = 3'd7;

	// Configuration register indexes.
	localparam logic [CIDX_CFG_W-1:0] CFG_HS_ENABLE   = 2'd0;
	localparam logic [CIDX_CFG_W-1:0] CFG_CHAN_MASK   = 2'd1;
	localparam logic [CIDX_CFG_W-1:0] CFG_REPLY_CORE  = 2'd2;

	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [HDR_W-1:0]  hdr_t;
	typedef logic [CIDX_W-1:0] cidx_t;

	typedef struct packed {
		logic [SRC_W-1:0]  source_core;
		logic [WORD_W-1:0] data_word;
	} in_item_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [WORD_W-1:0]  payload_word;
		logic [OFFS_W-1:0]  word_offset;
		logic [FBYTE_W-1:0] frame_bytes;
		logic               reply_valid;
		logic [WORD_W-1:0]  reply_word;
		logic [SRC_W-1:0]   reply_dest;
		logic               connected;
	} out_item_t;

	// Register file contents as seen by the datapath.
	typedef struct packed {
		logic              hs_enable;
		logic [MASK_W-1:0] chan_mask;
		logic [SRC_W-1:0]  reply_core;
	} cfg_t;

	// State read for the source of the current word.
	typedef struct packed {
		cnt_t count;
		hdr_t header;
		logic link;
	} ctx_t;

	// State update produced by one word.
	typedef struct packed {
		logic cnt_we;
		cnt_t cnt_new;
		logic hdr_we;
		hdr_t hdr_new;
		logic link_set;
	} upd_t;

endpackage

### rtl/nfr_if.sv
// ----------------------------------------------------------------------------
// nfr_if
// Valid/ready channel interfaces of the network frame reassembler.
// ----------------------------------------------------------------------------

// Received network words.
interface nfr_in_if;
	logic              valid;
	logic              ready;
	nfr_pkg::in_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

// Result items.
interface nfr_out_if;
	logic               valid;
	logic               ready;
	nfr_pkg::out_item_t item;

	modport source (output valid, output item, input ready);
	modport sink   (input valid, input item, output ready);
endinterface

// Configuration register writes.
interface nfr_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [nfr_pkg::CIDX_CFG_W-1:0]    index;
	logic [nfr_pkg::CDATA_W-1:0]       data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/nfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// nfr_cfg_regs
// Configuration registers: handshake enable, channel mask and reply core.
// ----------------------------------------------------------------------------
module nfr_cfg_regs (
	input  logic          clk,
	input  logic          arst_n,
	nfr_cfg_if.sink       cfg,
	output nfr_pkg::cfg_t regs
);

	nfr_pkg::cfg_t regs_q;

	// Writes are always taken; an index beyond the list changes nothing.
	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				nfr_pkg::CFG_HS_ENABLE: begin
					regs_q.hs_enable <= cfg.data[0];
				end
				nfr_pkg::CFG_CHAN_MASK: begin
					regs_q.chan_mask <= cfg.data[nfr_pkg::MASK_W-1:0];
				end
				nfr_pkg::CFG_REPLY_CORE: begin
					regs_q.reply_core <= cfg.data[nfr_pkg::SRC_W-1:0];
				end
				default: begin
					regs_q <= regs_q;
				end
			endcase
		end
	end

endmodule

### rtl/nfr_src_state.sv
// ----------------------------------------------------------------------------
// nfr_src_state
// Per-source byte counters and frame headers, plus the link flag.
// ----------------------------------------------------------------------------
module nfr_src_state (
	input  logic           clk,
	input  logic           arst_n,
	input  nfr_pkg::cidx_t idx,
	input  logic           we,
	input  nfr_pkg::upd_t  upd,
	output nfr_pkg::ctx_t  ctx
);

	nfr_pkg::cnt_t count_q  [nfr_pkg::CORE_COUNT];
	nfr_pkg::hdr_t header_q [nfr_pkg::CORE_COUNT];
	logic          link_q;

	// Context of the addressed source.
	assign ctx.count  = count_q[idx];
	assign ctx.header = header_q[idx];
	assign ctx.link   = link_q;

	// Byte counters and link flag reset to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < nfr_pkg::CORE_COUNT; i++) begin
				count_q[i] <= '0;
			end
			link_q <= 1'b0;
		end else if (we) begin
			if (upd.cnt_we) begin
				count_q[idx] <= upd.cnt_new;
			end
			if (upd.link_set) begin
				link_q <= 1'b1;
			end
		end
	end

	// Headers are written at the start of each frame before any read.
	always_ff @(posedge clk) begin
		if (we && upd.hdr_we) begin
			header_q[idx] <= upd.hdr_new;
		end
	end

endmodule

### rtl/nfr_frame_eval.sv
// ----------------------------------------------------------------------------
// nfr_frame_eval
// Classifies one received word and computes its result and state update.
// ----------------------------------------------------------------------------
module nfr_frame_eval (
	input  nfr_pkg::in_item_t  item,
	input  nfr_pkg::cfg_t      regs,
	input  nfr_pkg::ctx_t      ctx,
	output nfr_pkg::out_item_t res,
	output nfr_pkg::upd_t      upd
);

	logic          src_ok;
	logic          first;
	logic          bad;
	nfr_pkg::hdr_t hdr_eff;
	nfr_pkg::cnt_t cnt_inc;

	// Decode of the source and of the header that governs this frame.
	always_comb begin
		src_ok  = (32'(item.source_core) < nfr_pkg::CORE_COUNT)
			&& regs.chan_mask[item.source_core];
		first   = (ctx.count == '0);
		bad     = first && ((item.data_word == '0)
			|| (item.data_word > 32'(nfr_pkg::MAX_HDR)));
		hdr_eff = first ? item.data_word[nfr_pkg::HDR_W-1:0] : ctx.header;
		cnt_inc = ctx.count + nfr_pkg::CNT_W'(4);
	end

	// Result and update selection.
	always_comb begin
		res = '0;
		upd = '0;
		if (regs.hs_enable && !ctx.link) begin
			// Handshake pending: every word is consumed here.
			if (item.data_word == nfr_pkg::LINK_REQUEST) begin
				res.status      = nfr_pkg::ST_REPLY;
				res.reply_valid = 1'b1;
				res.reply_word  = nfr_pkg::LINK_RESPONSE;
				res.reply_dest  = regs.reply_core;
			end else if (item.data_word == nfr_pkg::LINK_RESPONSE) begin
				res.status   = nfr_pkg::ST_CONNECTED;
				upd.link_set = 1'b1;
			end else begin
				res.status = nfr_pkg::ST_IGNORED;
			end
		end else if (!src_ok) begin
			res.status = nfr_pkg::ST_NO_CHAN;
		end else if (ctx.count > nfr_pkg::CNT_W'(nfr_pkg::MAX_HDR)) begin
			res.status  = nfr_pkg::ST_OVERFLOW;
			upd.cnt_we  = 1'b1;
			upd.cnt_new = '0;
		end else begin
			res.payload_word = item.data_word;
			res.word_offset  = nfr_pkg::OFFS_W'(ctx.count >> 2);
			upd.hdr_we       = first;
			upd.hdr_new      = hdr_eff;
			upd.cnt_we       = 1'b1;
			if (bad) begin
				res.status  = nfr_pkg::ST_BAD_SIZE;
				upd.cnt_new = '0;
			end else begin
				res.frame_bytes = nfr_pkg::FBYTE_W'(hdr_eff);
				// Complete once count + 4 reaches header + 4.
				if (ctx.count >= nfr_pkg::CNT_W'(hdr_eff)) begin
					res.status  = nfr_pkg::ST_COMPLETE;
					upd.cnt_new = '0;
				end else begin
					res.status  = nfr_pkg::ST_PARTIAL;
					upd.cnt_new = cnt_inc;
				end
			end
		end
		res.connected = ctx.link | upd.link_set;
	end

endmodule

### rtl/noc_length_prefixed_frame_reassembler.sv
// ----------------------------------------------------------------------------
// noc_length_prefixed_frame_reassembler
// Reassembles length-prefixed frames from network words, per source core.
// ----------------------------------------------------------------------------
//
// Channel  Role    Payload                          Transfer
// rx       sink    source_core, data_word           valid && ready
// res      source  status ... connected             valid && ready
// cfg      sink    index, data                      valid && ready (ready = 1)
//
// One word enters the input register per cycle unless the result stalls;
// its result is registered as the word leaves the input register.
// The per-source counter update is a single compare-and-add between the input
// and result registers, and state is written when a word moves to the result.
// A stalled result holds the input stage; rx.ready is high unless it is held.
// Reset clears the byte counters, link flag, config registers and valid bits.
// ----------------------------------------------------------------------------
module noc_length_prefixed_frame_reassembler (
	input  logic      clk,
	input  logic      arst_n,
	nfr_in_if.sink    rx,
	nfr_out_if.source res,
	nfr_cfg_if.sink   cfg
);

	logic               valid_s1;
	nfr_pkg::in_item_t  item_s1;
	logic               res_valid_q;
	nfr_pkg::out_item_t res_item_q;
	logic               advance;
	nfr_pkg::cfg_t      regs;
	nfr_pkg::ctx_t      ctx;
	nfr_pkg::upd_t      upd;
	nfr_pkg::out_item_t eval_res;
	nfr_pkg::cidx_t     idx;

	// Stage 1 moves on when the result register is empty or being drained.
	assign advance  = valid_s1 && (!res_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;
	assign idx      = nfr_pkg::CIDX_W'(item_s1.source_core);

	nfr_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	nfr_src_state u_state (
		.clk    (clk),
		.arst_n (arst_n),
		.idx    (idx),
		.we     (advance),
		.upd    (upd),
		.ctx    (ctx)
	);

	nfr_frame_eval u_eval (
		.item (item_s1),
		.regs (regs),
		.ctx  (ctx),
		.res  (eval_res),
		.upd  (upd)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			item_s1 <= rx.item;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_item_q <= eval_res;
		end
	end

	assign res.valid = res_valid_q;
	assign res.item  = res_item_q;

endmodule

### rtl/nfr_checker.sv
// ----------------------------------------------------------------------------
// nfr_checker
// Port-level checks of the frame reassembler result channel.
// ----------------------------------------------------------------------------
module nfr_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               res_valid,
	input logic               res_ready,
	input nfr_pkg::out_item_t res_item
);

	// A stalled result holds its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result changed while stalled");

	// A reply is only issued with its status, word and an unconnected link.
	a_reply: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.reply_valid |->
			res_item.status == nfr_pkg::ST_REPLY
			&& res_item.reply_word == nfr_pkg::LINK_RESPONSE && !res_item.connected)
		else $error("malformed handshake reply");

	// A result reporting the link connected is not directly followed by a drop.
	a_link: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && res_item.connected |=>
			!(res_valid && !res_item.connected))
		else $error("link dropped after connecting");

	// Frames in progress always announce a nonzero length.
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_item.status == nfr_pkg::ST_PARTIAL
			|| res_item.status == nfr_pkg::ST_COMPLETE) |->
			res_item.frame_bytes != '0)
		else $error("frame result without length");

endmodule

bind noc_length_prefixed_frame_reassembler nfr_checker u_nfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_item  (res.item)
);

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the network frame reassembler. Words from the
// network are pushed through the rx channel with random gaps. Result
// transfers on the res channel are taken with random stalls. An in-bench
// predictor tracks per-source byte counts, headers and the link handshake,
// and every result is compared field by field against it.
// ----------------------------------------------------------------------------
module tb_top;
	import nfr_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n;

	nfr_in_if  rx();
	nfr_out_if res();
	nfr_cfg_if cfg();

	noc_length_prefixed_frame_reassembler DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.rx    (rx),
		.res   (res),
		.cfg   (cfg)
	);

	// Free-running clock, 8 ns period.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Words waiting to be sent and results waiting to be seen.
	in_item_t  pending_words[$];
	out_item_t expected_results[$];
	int        words_issued = 0;
	int        results_seen = 0;
	int        mismatches = 0;

	// Predictor copy of the block's registers and per-source state.
	logic              pred_hs_en;
	logic [MASK_W-1:0] pred_mask;
	logic [SRC_W-1:0]  pred_reply_core;
	cnt_t              rx_bytes[CORE_COUNT];
	logic [WORD_W-1:0] rx_header[CORE_COUNT];
	logic              link_up;
	logic              reply_sent;

	// Stimulus-side view, used to keep generated frames well formed.
	int                frame_left[CORE_COUNT];
	logic              gen_hs = 1'b0;
	logic              gen_link = 1'b0;
	logic [MASK_W-1:0] gen_mask = '0;

	// Pacing of both sides.
	int send_gap = 0;
	bit send_steady = 1'b0;
	int stall_left = 0;
	bit recv_steady = 1'b0;
	int quiet_cycles = 0;

	// Mostly short pauses, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// Computes the result of one word and advances the predicted state.
	function automatic out_item_t reassemble(input in_item_t w);
		out_item_t r;
		int        s;
		longint    cnt;
		longint    hdr;
		r = '0;
		s = w.source_core;
		if (pred_hs_en && !link_up) begin
			// While the link is down every word is consumed by the handshake.
			if (w.data_word == LINK_REQUEST) begin
				r.status      = ST_REPLY;
				r.reply_valid = 1'b1;
				r.reply_word  = LINK_RESPONSE;
				r.reply_dest  = pred_reply_core;
				reply_sent    = 1'b1;
			end else if (w.data_word == LINK_RESPONSE) begin
				r.status = ST_CONNECTED;
				link_up  = 1'b1;
			end else begin
				r.status = ST_IGNORED;
			end
		end else if (s >= CORE_COUNT || !pred_mask[s]) begin
			r.status = ST_NO_CHAN;
		end else if (longint'(rx_bytes[s]) + 4 > BUFFER_BYTES) begin
			r.status    = ST_OVERFLOW;
			rx_bytes[s] = '0;
		end else begin
			// The first word of a frame is its length in bytes.
			if (rx_bytes[s] == 0)
				rx_header[s] = w.data_word;
			cnt            = longint'(rx_bytes[s]);
			r.payload_word = w.data_word;
			r.word_offset  = OFFS_W'(cnt >> 2);
			cnt            = cnt + 4;
			hdr            = longint'(rx_header[s]);
			if (hdr == 0 || hdr > MAX_HDR) begin
				r.status     = ST_BAD_SIZE;
				rx_bytes[s]  = '0;
				rx_header[s] = '0;
			end else begin
				r.frame_bytes = FBYTE_W'(hdr);
				if (cnt >= hdr + 4) begin
					r.status    = ST_COMPLETE;
					rx_bytes[s] = '0;
				end else begin
					r.status    = ST_PARTIAL;
					rx_bytes[s] = cnt_t'(cnt);
				end
			end
		end
		r.connected = link_up;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
			mismatches++;
		end
	endtask

	// Queues one word and keeps the stimulus-side frame tracking in step.
	task automatic queue_word(input logic [SRC_W-1:0] src, input logic [WORD_W-1:0] word);
		in_item_t it;
		it.source_core = src;
		it.data_word   = word;
		pending_words.push_back(it);
		words_issued++;
		if (gen_hs && !gen_link) begin
			if (word == LINK_RESPONSE)
				gen_link = 1'b1;
		end else if (gen_mask[src]) begin
			if (frame_left[src] != 0)
				frame_left[src]--;
			else if (word != 0 && word <= MAX_HDR)
				frame_left[src] = (word + 3) / 4;
		end
	endtask

	// Writes one register once the block has gone quiet.
	task automatic write_reg(input logic [CIDX_CFG_W-1:0] idx, input logic [CDATA_W-1:0] value);
		do @(posedge clk); while (results_seen < words_issued);
		repeat (4) @(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		case (idx)
			CFG_HS_ENABLE: gen_hs   = value[0];
			CFG_CHAN_MASK: gen_mask = value[MASK_W-1:0];
			default: ;
		endcase
	endtask

	// Interleaved frames with random content, a hot source and some noise.
	task automatic random_frames(input int count, input int hot, input int hot_pct);
		logic [SRC_W-1:0]  s;
		logic [WORD_W-1:0] w;
		int                r;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < hot_pct)
				s = SRC_W'(hot);
			else if (r < 85 && gen_mask != 0)
				do s = SRC_W'($urandom_range(CORE_COUNT - 1)); while (!gen_mask[s]);
			else
				s = SRC_W'($urandom_range(CORE_COUNT - 1));
			r = $urandom_range(99);
			if (r < 6 || frame_left[s] != 0)
				w = $urandom;
			else if (r < 66)
				w = $urandom_range(1, 64);
			else if (r < 74)
				w = $urandom_range(65, 256);
			else if (r < 77)
				w = $urandom_range(257, MAX_HDR - 1);
			else if (r < 79)
				w = MAX_HDR;
			else if (r < 84)
				w = 0;
			else if (r < 88)
				w = MAX_HDR + 1;
			else
				w = $urandom;
			queue_word(s, w);
		end
	endtask

	// Words seen while the link is still down.
	task automatic handshake_words(input int count);
		logic [WORD_W-1:0] w;
		int                r;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 40)
				w = LINK_REQUEST;
			else if (r < 50)
				w = LINK_REQUEST ^ (32'h1 << $urandom_range(31));
			else if (r < 60)
				w = LINK_RESPONSE ^ (32'h1 << $urandom_range(31));
			else
				w = $urandom;
			queue_word(SRC_W'($urandom_range(CORE_COUNT - 1)), w);
		end
	endtask

	// Sender: one word per transfer, with a gap drawn after each word unless steady.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx.valid <= 1'b0;
			rx.item  <= '0;
			send_gap <= 0;
		end else if (!rx.valid || rx.ready) begin
			if (send_gap != 0) begin
				rx.valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (pending_words.size() != 0) begin
				rx.valid <= 1'b1;
				rx.item  <= pending_words.pop_front();
				send_gap <= send_steady ? 0 : pick_gap();
				if ($urandom_range(63) == 0)
					send_steady <= !send_steady;
			end else begin
				rx.valid <= 1'b0;
			end
		end
	end

	// Receiver: ready with random stalls, and steady stretches now and then.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.ready  <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			res.ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!recv_steady && $urandom_range(5) == 0) begin
			res.ready  <= 1'b0;
			stall_left <= pick_gap();
		end else begin
			res.ready <= 1'b1;
		end
		if (arst_n && res.valid && res.ready && $urandom_range(63) == 0)
			recv_steady <= !recv_steady;
	end

	// Monitor: tracks register writes, predicts each accepted word and checks
	// each result transfer against the oldest prediction.
	always @(posedge clk) begin : monitor
		out_item_t want;
		if (!arst_n) begin
			pred_hs_en      = 1'b0;
			pred_mask       = '0;
			pred_reply_core = '0;
			link_up         = 1'b0;
			reply_sent      = 1'b0;
			for (int i = 0; i < CORE_COUNT; i++) begin
				rx_bytes[i]  = '0;
				rx_header[i] = '0;
			end
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_HS_ENABLE:  pred_hs_en      = cfg.data[0];
					CFG_CHAN_MASK:  pred_mask       = cfg.data[MASK_W-1:0];
					CFG_REPLY_CORE: pred_reply_core = cfg.data[SRC_W-1:0];
					default: ;
				endcase
			end
			if (rx.valid && rx.ready)
				expected_results.push_back(reassemble(rx.item));
			if (res.valid && res.ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$display("%0t: result with nothing expected, actual %0h", $time, res.item);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					check_field("status", want.status, res.item.status);
					check_field("payload_word", want.payload_word, res.item.payload_word);
					check_field("word_offset", want.word_offset, res.item.word_offset);
					check_field("frame_bytes", want.frame_bytes, res.item.frame_bytes);
					check_field("reply_valid", want.reply_valid, res.item.reply_valid);
					check_field("reply_word", want.reply_word, res.item.reply_word);
					check_field("reply_dest", want.reply_dest, res.item.reply_dest);
					check_field("connected", want.connected, res.item.connected);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if (!arst_n || (rx.valid && rx.ready) || (res.valid && res.ready) ||
				(cfg.valid && cfg.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	// Test sequence.
	initial begin
		arst_n    = 1'b0;
		rx.valid  = 1'b0;
		rx.item   = '0;
		res.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data  = '0;
		for (int i = 0; i < CORE_COUNT; i++)
			frame_left[i] = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset defaults: no channel is registered, handshake words included.
		queue_word(4'd0, 32'h0000_0004);
		queue_word(4'd15, 32'hFFFF_FFFF);
		queue_word(4'd7, LINK_REQUEST);
		queue_word(4'd9, LINK_RESPONSE);

		// Directed frames with all channels open and the handshake off.
		write_reg(CFG_CHAN_MASK, 16'hFFFF);
		queue_word(4'd0, 32'd1);
		queue_word(4'd0, 32'hDEAD_BEEF);
		queue_word(4'd1, 32'd8);
		queue_word(4'd1, 32'h0000_0000);
		queue_word(4'd1, 32'hFFFF_FFFF);
		queue_word(4'd2, 32'd0);
		queue_word(4'd3, 32'(MAX_HDR + 1));
		queue_word(4'd4, 32'hFFFF_FFFF);
		queue_word(4'd6, LINK_REQUEST);
		queue_word(4'd7, 32'd4);
		queue_word(4'd7, LINK_RESPONSE);
		queue_word(4'd15, 32'd3);
		queue_word(4'd15, 32'h8000_0000);
		queue_word(4'd0, 32'd2);
		queue_word(4'd1, 32'd5);
		queue_word(4'd0, 32'hAAAA_AAAA);
		queue_word(4'd1, 32'h5555_5555);
		queue_word(4'd1, 32'h0000_0000);
		// A maximum-length frame on source 5, finished by the random part.
		queue_word(4'd5, 32'(MAX_HDR));
		queue_word(4'd5, 32'h1234_5678);

		// Random frames, source 5 hot so that its long frame completes.
		random_frames(400, 5, 70);
		write_reg(CFG_CHAN_MASK, 16'($urandom));
		write_reg(CFG_REPLY_CORE, 16'($urandom_range(CORE_COUNT - 1)));
		random_frames(250, $urandom_range(CORE_COUNT - 1), 20);
		write_reg(CFG_CHAN_MASK, 16'h0001);
		random_frames(100, 0, 30);

		// Handshake: noise and requests while the link is down.
		write_reg(CFG_CHAN_MASK, 16'hFFFF);
		write_reg(CFG_REPLY_CORE, 16'd0);
		write_reg(CFG_HS_ENABLE, 16'd1);
		queue_word(4'd3, 32'h0000_0010);
		queue_word(4'd0, LINK_REQUEST);
		queue_word(4'd8, LINK_REQUEST ^ 32'h1);
		queue_word(4'd12, LINK_RESPONSE ^ 32'h8000_0000);
		queue_word(4'd15, LINK_REQUEST);
		handshake_words(20);
		write_reg(CFG_REPLY_CORE, 16'd15);
		queue_word(4'd1, LINK_REQUEST);
		handshake_words(20);
		write_reg(CFG_REPLY_CORE, 16'($urandom_range(1, 14)));
		handshake_words(10);
		queue_word(4'd6, LINK_REQUEST);
		queue_word(4'd2, LINK_RESPONSE);

		// Link is up: frames flow again regardless of the handshake bit.
		random_frames(180, $urandom_range(CORE_COUNT - 1), 30);
		write_reg(CFG_HS_ENABLE, 16'd0);
		write_reg(CFG_CHAN_MASK, 16'hAAAA);
		random_frames(180, 1, 30);
		write_reg(CFG_CHAN_MASK, 16'h5555);
		write_reg(CFG_HS_ENABLE, 16'd1);
		random_frames(180, 2, 30);
		write_reg(CFG_CHAN_MASK, 16'hFFFF);
		write_reg(CFG_REPLY_CORE, 16'd0);
		random_frames(150, $urandom_range(CORE_COUNT - 1), 20);

		// Drain, then wait for any stray result before the verdict.
		do @(posedge clk); while (results_seen < words_issued);
		repeat (8) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
